FILE: rtl/sbto_pkg.sv
// Shared types, constants, font table and divider reciprocals for the text overlay core.
package sbto_pkg;

	// Screen and message store dimensions
	localparam int SCREEN_WIDTH  = 854;
	localparam int SCREEN_HEIGHT = 480;
	localparam int MAX_CHARS     = 16;

	// Font geometry
	localparam int GLYPH_ROWS = 7;
	localparam int GLYPH_COLS = 5;
	localparam int CELL_COLS  = GLYPH_COLS + 1;

	// Field widths
	localparam int PIX_X_W   = 10;
	localparam int PIX_Y_W   = 9;
	localparam int INDEX_W   = 4;
	localparam int CODE_W    = 8;
	localparam int CHAN_W    = 8;
	localparam int COLOR_W   = 3 * CHAN_W;
	localparam int ORIGIN_W  = 12;
	localparam int SCALE_W   = 5;
	localparam int LEN_W     = 5;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = COLOR_W;

	// Distance from the origin: signed difference and its non-negative part
	localparam int DIFF_W = ORIGIN_W + 1;
	localparam int DIST_W = ORIGIN_W;

	// Division by scale through a reciprocal, exact for any DIST_W-bit dividend
	localparam int RECIP_K = DIST_W + SCALE_W;
	localparam int RECIP_W = RECIP_K + 1;
	localparam int PROD_W  = DIST_W + RECIP_W;
	localparam int QUOT_W  = PROD_W - RECIP_K;
	localparam int DIV_ONE = 2 ** RECIP_K;
	localparam int SCALE_CODES = 2 ** SCALE_W;

	// Message store addressing
	localparam int CHAR_ADDR_W = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;

	// Dot column within the message, split into cell and column by a reciprocal of six
	localparam int DOT_W      = $clog2(CELL_COLS * MAX_CHARS);
	localparam int D6_K       = DOT_W + 3;
	localparam int D6_M       = (2 ** D6_K + CELL_COLS - 1) / CELL_COLS;
	localparam int D6_PROD_W  = DOT_W + D6_K;
	localparam int ROW_W      = 3;
	localparam int COL_W      = 3;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Register reset values
	localparam logic [ORIGIN_W-1:0] ORIGIN_X_RESET    = ORIGIN_W'(97);
	localparam logic [ORIGIN_W-1:0] ORIGIN_Y_RESET    = ORIGIN_W'(205);
	localparam logic [SCALE_W-1:0]  SCALE_RESET       = SCALE_W'(10);
	localparam logic [COLOR_W-1:0]  TEXT_COLOR_RESET  = COLOR_W'(24'hFFFFFF);
	localparam logic [COLOR_W-1:0]  BG_COLOR_RESET    = COLOR_W'(20);
	localparam logic [LEN_W-1:0]    TEXT_LENGTH_RESET = LEN_W'(0);

	// ceil(2^RECIP_K / scale); scale zero never reaches the divider
	localparam logic [RECIP_W-1:0] RECIP_TABLE [SCALE_CODES] = '{
		RECIP_W'(0),
		RECIP_W'((DIV_ONE + 0) / 1),
		RECIP_W'((DIV_ONE + 1) / 2),
		RECIP_W'((DIV_ONE + 2) / 3),
		RECIP_W'((DIV_ONE + 3) / 4),
		RECIP_W'((DIV_ONE + 4) / 5),
		RECIP_W'((DIV_ONE + 5) / 6),
		RECIP_W'((DIV_ONE + 6) / 7),
		RECIP_W'((DIV_ONE + 7) / 8),
		RECIP_W'((DIV_ONE + 8) / 9),
		RECIP_W'((DIV_ONE + 9) / 10),
		RECIP_W'((DIV_ONE + 10) / 11),
		RECIP_W'((DIV_ONE + 11) / 12),
		RECIP_W'((DIV_ONE + 12) / 13),
		RECIP_W'((DIV_ONE + 13) / 14),
		RECIP_W'((DIV_ONE + 14) / 15),
		RECIP_W'((DIV_ONE + 15) / 16),
		RECIP_W'((DIV_ONE + 16) / 17),
		RECIP_W'((DIV_ONE + 17) / 18),
		RECIP_W'((DIV_ONE + 18) / 19),
		RECIP_W'((DIV_ONE + 19) / 20),
		RECIP_W'((DIV_ONE + 20) / 21),
		RECIP_W'((DIV_ONE + 21) / 22),
		RECIP_W'((DIV_ONE + 22) / 23),
		RECIP_W'((DIV_ONE + 23) / 24),
		RECIP_W'((DIV_ONE + 24) / 25),
		RECIP_W'((DIV_ONE + 25) / 26),
		RECIP_W'((DIV_ONE + 26) / 27),
		RECIP_W'((DIV_ONE + 27) / 28),
		RECIP_W'((DIV_ONE + 28) / 29),
		RECIP_W'((DIV_ONE + 29) / 30),
		RECIP_W'((DIV_ONE + 30) / 31)
	};

	// Character codes present in the font
	localparam logic [CODE_W-1:0] CODE_H = 8'h48;
	localparam logic [CODE_W-1:0] CODE_E = 8'h45;
	localparam logic [CODE_W-1:0] CODE_L = 8'h4C;
	localparam logic [CODE_W-1:0] CODE_O = 8'h4F;
	localparam logic [CODE_W-1:0] CODE_W_CHAR = 8'h57;
	localparam logic [CODE_W-1:0] CODE_R = 8'h52;
	localparam logic [CODE_W-1:0] CODE_D = 8'h44;

	typedef logic [GLYPH_COLS-1:0] glyph_row_t;

	// Rows top to bottom, leftmost dot in the highest bit
	localparam glyph_row_t GLYPH_H [GLYPH_ROWS] = '{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
	localparam glyph_row_t GLYPH_E [GLYPH_ROWS] = '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
	localparam glyph_row_t GLYPH_L [GLYPH_ROWS] = '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
	localparam glyph_row_t GLYPH_O [GLYPH_ROWS] = '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
	localparam glyph_row_t GLYPH_W [GLYPH_ROWS] = '{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11};
	localparam glyph_row_t GLYPH_R [GLYPH_ROWS] = '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
	localparam glyph_row_t GLYPH_D [GLYPH_ROWS] = '{5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORIGIN_X,
		CFG_ORIGIN_Y,
		CFG_SCALE,
		CFG_TEXT_COLOR,
		CFG_BG_COLOR,
		CFG_TEXT_LENGTH
	} cfg_index_t;

	typedef struct packed {
		logic                func;
		logic [PIX_X_W-1:0]  pixel_x;
		logic [PIX_Y_W-1:0]  pixel_y;
		logic [INDEX_W-1:0]  char_index;
		logic [CODE_W-1:0]   char_code;
	} in_item_t;

	typedef struct packed {
		logic              is_text;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} out_item_t;

	// Live configuration plus derived values: the reciprocal, looked up at write time, and the cell limit
	typedef struct packed {
		logic [ORIGIN_W-1:0] origin_x;
		logic [ORIGIN_W-1:0] origin_y;
		logic [SCALE_W-1:0]  scale;
		logic [COLOR_W-1:0]  text_color;
		logic [COLOR_W-1:0]  background_color;
		logic [RECIP_W-1:0]  recip;
		logic [DOT_W-1:0]    cell_limit;
	} cfg_t;

	// Classified item as it travels from front to back
	typedef struct packed {
		logic               is_load;
		logic               wr_en;
		logic [INDEX_W-1:0] index;
		logic [CODE_W-1:0]  code;
		logic               off;
		logic [DIST_W-1:0]  dx;
		logic [DIST_W-1:0]  dy;
	} op_t;

	function automatic glyph_row_t glyph_row(input logic [CODE_W-1:0] code,
			input logic [ROW_W-1:0] row);
		glyph_row_t rows [GLYPH_ROWS];
		rows = '{default: '0};
		case (code)
			CODE_H:      rows = GLYPH_H;
			CODE_E:      rows = GLYPH_E;
			CODE_L:      rows = GLYPH_L;
			CODE_O:      rows = GLYPH_O;
			CODE_W_CHAR: rows = GLYPH_W;
			CODE_R:      rows = GLYPH_R;
			CODE_D:      rows = GLYPH_D;
			default:     rows = '{default: '0};
		endcase
		if (int'(row) >= GLYPH_ROWS) begin
			return '0;
		end
		return rows[row];
	endfunction

endpackage

FILE: rtl/scaled_bitmap_text_overlay_core.sv
// Top level of the scaled bitmap text overlay: configuration registers, front, queue and back.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid/in_stall   | in_data (func, pixel_x, pixel_y, char_index,
//           |           |                     |          char_code)
//   out     | output    | out_valid/out_stall | out_data (is_text, red, green, blue)
//   cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item per cycle sustained while the output is not stalled; an item's result is offered on
// out_valid after the queue slot written at its input transfer, then the pop register, scale
// reciprocal product, cell split by six, message store registered read and output register.
// arst_n clears control state and loads the register reset values; the message store has
// no reset and needs no clearing pass, so items are taken from the first cycle after reset.
// A stall on the output holds the whole back pipeline; the four-entry queue keeps taking
// input transfers until it fills.
module scaled_bitmap_text_overlay_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  sbto_pkg::in_item_t                in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output sbto_pkg::out_item_t               out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sbto_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sbto_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic [sbto_pkg::ORIGIN_W-1:0] origin_x_q;
	logic [sbto_pkg::ORIGIN_W-1:0] origin_y_q;
	logic [sbto_pkg::SCALE_W-1:0]  scale_q;
	logic [sbto_pkg::COLOR_W-1:0]  text_color_q;
	logic [sbto_pkg::COLOR_W-1:0]  bg_color_q;
	logic [sbto_pkg::LEN_W-1:0]    text_length_q;
	logic [sbto_pkg::RECIP_W-1:0]  recip_q;

	int                 len_used;
	sbto_pkg::cfg_t     cfg;
	sbto_pkg::op_t      front_op;
	sbto_pkg::op_t      queue_head;
	logic               push;
	logic               pop;
	logic               queue_full;
	logic               queue_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q    <= sbto_pkg::ORIGIN_X_RESET;
			origin_y_q    <= sbto_pkg::ORIGIN_Y_RESET;
			scale_q       <= sbto_pkg::SCALE_RESET;
			text_color_q  <= sbto_pkg::TEXT_COLOR_RESET;
			bg_color_q    <= sbto_pkg::BG_COLOR_RESET;
			text_length_q <= sbto_pkg::TEXT_LENGTH_RESET;
			recip_q       <= sbto_pkg::RECIP_TABLE[sbto_pkg::SCALE_RESET];
		end else if (cfg_valid && cfg_ready) begin
			case (sbto_pkg::cfg_index_t'(cfg_index))
				sbto_pkg::CFG_ORIGIN_X:    origin_x_q <= cfg_data[sbto_pkg::ORIGIN_W-1:0];
				sbto_pkg::CFG_ORIGIN_Y:    origin_y_q <= cfg_data[sbto_pkg::ORIGIN_W-1:0];
				sbto_pkg::CFG_SCALE: begin
					scale_q <= cfg_data[sbto_pkg::SCALE_W-1:0];
					// Look up the reciprocal now so the datapath only multiplies
					recip_q <= sbto_pkg::RECIP_TABLE[cfg_data[sbto_pkg::SCALE_W-1:0]];
				end
				sbto_pkg::CFG_TEXT_COLOR:  text_color_q <= cfg_data[sbto_pkg::COLOR_W-1:0];
				sbto_pkg::CFG_BG_COLOR:    bg_color_q <= cfg_data[sbto_pkg::COLOR_W-1:0];
				sbto_pkg::CFG_TEXT_LENGTH: text_length_q <= cfg_data[sbto_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the length to the store size; cell_limit is the first dot column past the text
	assign len_used = (int'(text_length_q) > sbto_pkg::MAX_CHARS)
		? sbto_pkg::MAX_CHARS : int'(text_length_q);

	always_comb begin
		cfg.origin_x         = origin_x_q;
		cfg.origin_y         = origin_y_q;
		cfg.scale            = scale_q;
		cfg.text_color       = text_color_q;
		cfg.background_color = bg_color_q;
		cfg.recip            = recip_q;
		cfg.cell_limit       = sbto_pkg::DOT_W'(len_used * sbto_pkg::CELL_COLS);
	end

	sbto_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.cfg       (cfg),
		.queue_full(queue_full),
		.push      (push),
		.op        (front_op)
	);

	sbto_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(front_op),
		.full     (queue_full),
		.pop      (pop),
		.head     (queue_head),
		.empty    (queue_empty)
	);

	sbto_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.queue_empty(queue_empty),
		.queue_head (queue_head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

FILE: rtl/sbto_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sbto_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/sbto_front.sv
// Front end: takes input transfers, works out pixel offsets and sorts loads from queries.
module sbto_front (
	input  logic              in_valid,
	output logic              in_stall,
	input  sbto_pkg::in_item_t in_data,
	input  sbto_pkg::cfg_t    cfg,
	input  logic              queue_full,
	output logic              push,
	output sbto_pkg::op_t     op
);

	logic [sbto_pkg::DIFF_W-1:0] dx_full;
	logic [sbto_pkg::DIFF_W-1:0] dy_full;
	logic                        off_screen;

	assign in_stall = queue_full;
	assign push     = in_valid && !queue_full;

	// Sign-extend the origin, zero-extend the pixel position
	assign dx_full = sbto_pkg::DIFF_W'(in_data.pixel_x)
		- {cfg.origin_x[sbto_pkg::ORIGIN_W-1], cfg.origin_x};
	assign dy_full = sbto_pkg::DIFF_W'(in_data.pixel_y)
		- {cfg.origin_y[sbto_pkg::ORIGIN_W-1], cfg.origin_y};

	assign off_screen = (int'(in_data.pixel_x) >= sbto_pkg::SCREEN_WIDTH)
		|| (int'(in_data.pixel_y) >= sbto_pkg::SCREEN_HEIGHT);

	always_comb begin
		op.is_load = !in_data.func;
		op.wr_en   = int'(in_data.char_index) < sbto_pkg::MAX_CHARS;
		op.index   = in_data.char_index;
		op.code    = in_data.char_code;
		// Left of or above the origin, off screen or zero scale: never text
		op.off     = (cfg.scale == '0) || off_screen
			|| dx_full[sbto_pkg::DIFF_W-1] || dy_full[sbto_pkg::DIFF_W-1];
		op.dx      = dx_full[sbto_pkg::DIST_W-1:0];
		op.dy      = dy_full[sbto_pkg::DIST_W-1:0];
	end

endmodule

FILE: rtl/sbto_queue.sv
// Short register FIFO that decouples the front end from the back end.
module sbto_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sbto_pkg::op_t push_data,
	output logic          full,
	input  logic          pop,
	output sbto_pkg::op_t head,
	output logic          empty
);

	sbto_pkg::op_t                entry_q [sbto_pkg::QUEUE_DEPTH];
	logic [sbto_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [sbto_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [sbto_pkg::QCNT_W-1:0]  count_q;

	assign full  = int'(count_q) == sbto_pkg::QUEUE_DEPTH;
	assign empty = count_q == '0;
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == sbto_pkg::QUEUE_DEPTH - 1)
					? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == sbto_pkg::QUEUE_DEPTH - 1)
					? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: rtl/sbto_back.sv
// Back end: divides offsets by scale, reads the message store and picks the pixel colour.
module sbto_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sbto_pkg::cfg_t       cfg,
	input  logic                 queue_empty,
	input  sbto_pkg::op_t        queue_head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output sbto_pkg::out_item_t  out_data
);

	logic advance;

	// Stage 1: popped item
	logic          valid_s1;
	sbto_pkg::op_t op_s1;

	// Stage 2: reciprocal products
	logic                        valid_s2;
	sbto_pkg::op_t               op_s2;
	logic [sbto_pkg::PROD_W-1:0] prod_x_s2;
	logic [sbto_pkg::PROD_W-1:0] prod_y_s2;

	// Stage 3: cell, dot column and row
	logic                             valid_s3;
	logic                             is_load_s3;
	logic                             wr_en_s3;
	logic [sbto_pkg::INDEX_W-1:0]     index_s3;
	logic [sbto_pkg::CODE_W-1:0]      code_s3;
	logic                             hit_s3;
	logic [sbto_pkg::CHAR_ADDR_W-1:0] cell_s3;
	logic [sbto_pkg::COL_W-1:0]       col_s3;
	logic [sbto_pkg::ROW_W-1:0]       row_s3;

	// Stage 4: glyph code from the store
	logic                        valid_s4;
	logic                        is_load_s4;
	logic                        hit_s4;
	logic [sbto_pkg::COL_W-1:0]  col_s4;
	logic [sbto_pkg::ROW_W-1:0]  row_s4;
	logic [sbto_pkg::CODE_W-1:0] char_s4;

	logic                out_valid_q;
	sbto_pkg::out_item_t out_q;

	logic [sbto_pkg::QUOT_W-1:0]    dot_x;
	logic [sbto_pkg::QUOT_W-1:0]    dot_y;
	logic [sbto_pkg::DOT_W-1:0]     dot;
	logic [sbto_pkg::D6_PROD_W-1:0] d6_prod;
	logic [sbto_pkg::DOT_W-1:0]     cell_c;
	logic [sbto_pkg::COL_W-1:0]     col_c;
	logic                           hit_c;

	sbto_pkg::glyph_row_t         row_bits;
	logic [sbto_pkg::COL_W-1:0]   bit_sel;
	logic                         lit;
	logic [sbto_pkg::COLOR_W-1:0] colour;
	sbto_pkg::out_item_t          result;

	// The whole pipeline moves together whenever the output register can take a transfer
	assign advance   = !out_valid_q || !out_stall;
	assign pop       = advance && !queue_empty;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Floor division by scale is exact through the reciprocal
	assign dot_x = prod_x_s2[sbto_pkg::PROD_W-1:sbto_pkg::RECIP_K];
	assign dot_y = prod_y_s2[sbto_pkg::PROD_W-1:sbto_pkg::RECIP_K];
	assign dot   = sbto_pkg::DOT_W'(dot_x);

	// Split the dot column into cell and column within the cell
	assign d6_prod = sbto_pkg::D6_PROD_W'(dot) * sbto_pkg::D6_PROD_W'(sbto_pkg::D6_M);
	assign cell_c  = sbto_pkg::DOT_W'(d6_prod >> sbto_pkg::D6_K);
	assign col_c   = sbto_pkg::COL_W'(dot - sbto_pkg::DOT_W'(cell_c * sbto_pkg::CELL_COLS));

	assign hit_c = !op_s2.off
		&& (int'(dot_y) < sbto_pkg::GLYPH_ROWS)
		&& (int'(dot_x) < int'(cfg.cell_limit))
		&& (int'(col_c) < sbto_pkg::GLYPH_COLS);

	sbto_ram #(
		.WIDTH(sbto_pkg::CODE_W),
		.DEPTH(sbto_pkg::MAX_CHARS)
	) u_store (
		.clk  (clk),
		.we   (advance && valid_s3 && is_load_s3 && wr_en_s3),
		.waddr(sbto_pkg::CHAR_ADDR_W'(index_s3)),
		.wdata(code_s3),
		.re   (advance),
		.raddr(cell_s3),
		.rdata(char_s4)
	);

	assign row_bits = sbto_pkg::glyph_row(char_s4, row_s4);
	assign bit_sel  = sbto_pkg::COL_W'(sbto_pkg::GLYPH_COLS - 1) - col_s4;
	assign lit      = !is_load_s4 && hit_s4 && row_bits[bit_sel];
	assign colour   = lit ? cfg.text_color : cfg.background_color;

	always_comb begin
		result.is_text = lit;
		result.red     = colour[3*sbto_pkg::CHAN_W-1:2*sbto_pkg::CHAN_W];
		result.green   = colour[2*sbto_pkg::CHAN_W-1:sbto_pkg::CHAN_W];
		result.blue    = colour[sbto_pkg::CHAN_W-1:0];
		if (is_load_s4) begin
			result = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= !queue_empty;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			op_s1      <= queue_head;

			op_s2      <= op_s1;
			prod_x_s2  <= sbto_pkg::PROD_W'(op_s1.dx) * sbto_pkg::PROD_W'(cfg.recip);
			prod_y_s2  <= sbto_pkg::PROD_W'(op_s1.dy) * sbto_pkg::PROD_W'(cfg.recip);

			is_load_s3 <= op_s2.is_load;
			wr_en_s3   <= op_s2.wr_en;
			index_s3   <= op_s2.index;
			code_s3    <= op_s2.code;
			hit_s3     <= hit_c;
			cell_s3    <= sbto_pkg::CHAR_ADDR_W'(cell_c);
			col_s3     <= col_c;
			row_s3     <= sbto_pkg::ROW_W'(dot_y);

			is_load_s4 <= is_load_s3;
			hit_s4     <= hit_s3;
			col_s4     <= col_s3;
			row_s4     <= row_s3;

			out_q      <= result;
		end
	end

endmodule
